/* sv/i2cmbe_pkg.sv */
// ----------------------------------------------------------------------------
// i2cmbe_pkg
// Shared types and constants for the I2C master bit engine: word layouts,
// command codes and register map.
// ----------------------------------------------------------------------------
package i2cmbe_pkg;

  localparam int BYTE_BITS  = 8;
  localparam int S_TDATA_W  = 16;
  localparam int S_TUSER_W  = 4;
  localparam int M_TDATA_W  = 16;
  localparam int PADDR_W    = 3;
  localparam int PDATA_W    = 32;
  localparam int UNIT_W     = 16;
  localparam int TOUT_W     = 8;

  // command codes
  localparam logic [2:0] CMD_START = 3'd0;
  localparam logic [2:0] CMD_STOP  = 3'd1;
  localparam logic [2:0] CMD_SEND  = 3'd2;
  localparam logic [2:0] CMD_WACK  = 3'd3;
  localparam logic [2:0] CMD_ACK   = 3'd4;
  localparam logic [2:0] CMD_NACK  = 3'd5;
  localparam logic [2:0] CMD_READ  = 3'd6;

  // register index, taken from paddr[2]
  localparam logic REG_TICKS_PER_UNIT = 1'b0;
  localparam logic REG_ACK_TIMEOUT    = 1'b1;

  localparam logic [UNIT_W-1:0] TICKS_PER_UNIT_RST = 16'd72;
  localparam logic [TOUT_W-1:0] ACK_TIMEOUT_RST    = 8'd250;

  // delay lengths in units
  localparam logic [2:0] DLY_LONG  = 3'd4;
  localparam logic [2:0] DLY_MID   = 3'd2;
  localparam logic [2:0] DLY_SHORT = 3'd1;
  localparam logic [2:0] DLY_NONE  = 3'd0;

  // input word, last field in the lowest bits
  typedef struct packed {
    logic [5:0] pad;
    logic       sda_in;
    logic       ack_after_read;
    logic [7:0] tx_byte;
  } in_word_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic       cmd_valid;
  } in_user_t;

  // result word, last field in the lowest bits
  typedef struct packed {
    logic [1:0] pad;
    logic       ack_missing;
    logic [7:0] rx_byte;
    logic       done_res;
    logic       busy_res;
    logic       sda_driving;
    logic       sda_level;
    logic       scl_level;
  } out_word_t;

endpackage

/* sv/i2c_master_bit_engine_core.sv */
// ----------------------------------------------------------------------------
// i2c_master_bit_engine_core
// I2C master line sequencer stepped by one input word per bus tick; each
// tick returns the driven line levels and command status.
// ----------------------------------------------------------------------------
//  channel  | direction | contents
//  ---------+-----------+-----------------------------------------------------
//  s_*      | in        | one tick: command (tuser), byte/ack choice/SDA (tdata)
//  m_*      | out       | one status word per tick
//  APB      | in/out    | ticks_per_unit (addr 0), ack_timeout (addr 4)
//
// One word in, one word out, one word per cycle unless m_tready stalls the
// output: the sequencer state and the result register both update in the
// accepting cycle, and the result is valid in the cycle after acceptance.
// s_tready drops only while a result waits and m_tready is low.
// rst is synchronous; it restores the register defaults and idle lines.
module i2c_master_bit_engine_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // [7:0] tx_byte, [8] ack_after_read, [9] sda_in, [15:10] zero
  input  logic [i2cmbe_pkg::S_TDATA_W-1:0] s_tdata,
  // [0] cmd_valid, [3:1] cmd
  input  logic [i2cmbe_pkg::S_TUSER_W-1:0] s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // [0] scl_level, [1] sda_level, [2] sda_driving, [3] busy_res,
  // [4] done_res, [12:5] rx_byte, [13] ack_missing, [15:14] zero
  output logic [i2cmbe_pkg::M_TDATA_W-1:0] m_tdata,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [i2cmbe_pkg::PADDR_W-1:0]   paddr,
  input  logic [i2cmbe_pkg::PDATA_W-1:0]   pwdata,
  output logic [i2cmbe_pkg::PDATA_W-1:0]   prdata,
  output logic                             pready
);
  import i2cmbe_pkg::*;

  typedef enum logic [4:0] {
    PH_IDLE      = 5'd0,
    PH_START_A   = 5'd1,
    PH_START_B   = 5'd2,
    PH_STOP_A    = 5'd3,
    PH_STOP_B    = 5'd4,
    PH_WACK_A    = 5'd5,
    PH_WACK_B    = 5'd6,
    PH_WACK_POLL = 5'd7,
    PH_ACK_A     = 5'd8,
    PH_ACK_B     = 5'd9,
    PH_SEND_A    = 5'd10,
    PH_SEND_B    = 5'd11,
    PH_SEND_C    = 5'd12,
    PH_READ_A    = 5'd13,
    PH_READ_B    = 5'd14,
    PH_READN_A   = 5'd15,
    PH_READN_B   = 5'd16
  } phase_t;

  // configuration
  logic [UNIT_W-1:0] ticks_per_unit;
  logic [TOUT_W-1:0] ack_timeout;
  logic              cfg_wr;

  // sequencer state
  phase_t            phase, phase_next;
  logic [UNIT_W-1:0] unit_counter, unit_counter_next;
  logic [2:0]        delay_units_left, delay_units_left_next;
  logic [3:0]        bit_index, bit_index_next;
  logic [7:0]        shift_reg, shift_reg_next;
  logic [7:0]        rx_reg, rx_reg_next;
  logic [TOUT_W-1:0] timeout_counter, timeout_counter_next;
  logic              scl, scl_next;
  logic              sda, sda_next;
  logic              drv, drv_next;
  logic              ack_flag, ack_flag_next;
  logic              done_next;

  // working values
  in_word_t          in_w;
  in_user_t          in_u;
  out_word_t         res, res_next;
  logic              accept;
  logic [UNIT_W-1:0] tpu_eff;
  logic [UNIT_W:0]   uc_inc;
  logic [3:0]        bi_inc;
  logic [TOUT_W-1:0] tc_inc;
  logic [7:0]        shift_sh;
  logic              with_ack;

  assign in_w     = in_word_t'(s_tdata);
  assign in_u     = in_user_t'(s_tuser);
  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign m_tdata  = res;

  // APB
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  always_comb begin
    if (paddr[2] == REG_ACK_TIMEOUT) begin
      prdata = {{(PDATA_W-TOUT_W){1'b0}}, ack_timeout};
    end else begin
      prdata = {{(PDATA_W-UNIT_W){1'b0}}, ticks_per_unit};
    end
  end

  assign tpu_eff  = (ticks_per_unit == '0) ? UNIT_W'(1) : ticks_per_unit;
  assign uc_inc   = {1'b0, unit_counter} + (UNIT_W+1)'(1);
  assign bi_inc   = bit_index + 4'd1;
  assign tc_inc   = (timeout_counter == '1) ? timeout_counter
                                            : timeout_counter + TOUT_W'(1);
  assign shift_sh = {shift_reg[6:0], 1'b0};
  assign with_ack = (phase == PH_READ_A) || (phase == PH_READ_B);

  always_comb begin
    phase_next            = phase;
    unit_counter_next     = unit_counter;
    delay_units_left_next = delay_units_left;
    bit_index_next        = bit_index;
    shift_reg_next        = shift_reg;
    rx_reg_next           = rx_reg;
    timeout_counter_next  = timeout_counter;
    scl_next              = scl;
    sda_next              = sda;
    drv_next              = drv;
    ack_flag_next         = ack_flag;
    done_next             = 1'b0;

    if (phase == PH_IDLE) begin
      if (in_u.cmd_valid) begin
        unique case (in_u.cmd)
          CMD_START: begin
            drv_next = 1'b1; sda_next = 1'b1; scl_next = 1'b1;
            phase_next = PH_START_A; delay_units_left_next = DLY_LONG;
            unit_counter_next = '0;
          end
          CMD_STOP: begin
            drv_next = 1'b1; scl_next = 1'b0; sda_next = 1'b0;
            phase_next = PH_STOP_A; delay_units_left_next = DLY_LONG;
            unit_counter_next = '0;
          end
          CMD_SEND: begin
            drv_next = 1'b1; scl_next = 1'b0;
            shift_reg_next = in_w.tx_byte;
            bit_index_next = '0;
            sda_next = in_w.tx_byte[7];
            phase_next = PH_SEND_A; delay_units_left_next = DLY_MID;
            unit_counter_next = '0;
          end
          CMD_WACK: begin
            ack_flag_next = 1'b0;
            drv_next = 1'b0; sda_next = 1'b1;
            phase_next = PH_WACK_A; delay_units_left_next = DLY_SHORT;
            unit_counter_next = '0;
          end
          CMD_ACK, CMD_NACK: begin
            scl_next = 1'b0; drv_next = 1'b1;
            sda_next = (in_u.cmd == CMD_NACK);
            phase_next = PH_ACK_A; delay_units_left_next = DLY_MID;
            unit_counter_next = '0;
          end
          CMD_READ: begin
            drv_next = 1'b0; scl_next = 1'b0;
            shift_reg_next = '0;
            bit_index_next = '0;
            phase_next = in_w.ack_after_read ? PH_READ_A : PH_READN_A;
            delay_units_left_next = DLY_MID;
            unit_counter_next = '0;
          end
          default: ;  // unused code, stay idle
        endcase
      end
    end else if (phase == PH_WACK_POLL) begin
      if (!in_w.sda_in) begin
        scl_next = 1'b0;
        phase_next = PH_IDLE; delay_units_left_next = '0;
        unit_counter_next = '0; done_next = 1'b1;
      end else begin
        timeout_counter_next = tc_inc;
        if (tc_inc > ack_timeout) begin
          ack_flag_next = 1'b1;
          drv_next = 1'b1; scl_next = 1'b0; sda_next = 1'b0;
          phase_next = PH_STOP_A; delay_units_left_next = DLY_LONG;
          unit_counter_next = '0;
        end
      end
    end else begin
      // delay count: one unit every tpu_eff ticks
      if (uc_inc >= {1'b0, tpu_eff}) begin
        unit_counter_next = '0;
        if (delay_units_left != '0) begin
          delay_units_left_next = delay_units_left - 3'd1;
        end
      end else begin
        unit_counter_next = uc_inc[UNIT_W-1:0];
      end

      if (delay_units_left_next == '0) begin
        unit_counter_next = '0;
        unique case (phase)
          PH_START_A: begin
            sda_next = 1'b0;
            phase_next = PH_START_B; delay_units_left_next = DLY_LONG;
          end
          PH_START_B: begin
            scl_next = 1'b0;
            phase_next = PH_IDLE; done_next = 1'b1;
          end
          PH_STOP_A: begin
            scl_next = 1'b1; sda_next = 1'b1;
            phase_next = PH_STOP_B; delay_units_left_next = DLY_LONG;
          end
          PH_STOP_B: begin
            phase_next = PH_IDLE; done_next = 1'b1;
          end
          PH_WACK_A: begin
            scl_next = 1'b1;
            phase_next = PH_WACK_B; delay_units_left_next = DLY_SHORT;
          end
          PH_WACK_B: begin
            timeout_counter_next = '0;
            phase_next = PH_WACK_POLL; delay_units_left_next = DLY_NONE;
          end
          PH_ACK_A: begin
            scl_next = 1'b1;
            phase_next = PH_ACK_B; delay_units_left_next = DLY_MID;
          end
          PH_ACK_B: begin
            scl_next = 1'b0;
            phase_next = PH_IDLE; done_next = 1'b1;
          end
          PH_SEND_A: begin
            scl_next = 1'b1;
            phase_next = PH_SEND_B; delay_units_left_next = DLY_MID;
          end
          PH_SEND_B: begin
            scl_next = 1'b0;
            phase_next = PH_SEND_C; delay_units_left_next = DLY_MID;
          end
          PH_SEND_C: begin
            bit_index_next = bi_inc;
            if (bi_inc >= 4'(BYTE_BITS)) begin
              phase_next = PH_IDLE; done_next = 1'b1;
            end else begin
              shift_reg_next = shift_sh;
              sda_next = shift_sh[7];
              phase_next = PH_SEND_A; delay_units_left_next = DLY_MID;
            end
          end
          PH_READ_A, PH_READN_A: begin
            scl_next = 1'b1;
            shift_reg_next = {shift_reg[6:0], in_w.sda_in};
            phase_next = with_ack ? PH_READ_B : PH_READN_B;
            delay_units_left_next = DLY_SHORT;
          end
          PH_READ_B, PH_READN_B: begin
            bit_index_next = bi_inc;
            if (bi_inc >= 4'(BYTE_BITS)) begin
              // byte complete: ack bit follows straight away
              rx_reg_next = shift_reg;
              scl_next = 1'b0; drv_next = 1'b1; sda_next = !with_ack;
              phase_next = PH_ACK_A; delay_units_left_next = DLY_MID;
            end else begin
              scl_next = 1'b0;
              phase_next = with_ack ? PH_READ_A : PH_READN_A;
              delay_units_left_next = DLY_MID;
            end
          end
          default: begin
            phase_next = PH_IDLE;
          end
        endcase
      end
    end
  end

  always_comb begin
    res_next             = '0;
    res_next.scl_level   = scl_next;
    res_next.sda_level   = sda_next;
    res_next.sda_driving = drv_next;
    res_next.busy_res    = (phase_next != PH_IDLE);
    res_next.done_res    = done_next;
    res_next.rx_byte     = rx_reg_next;
    res_next.ack_missing = ack_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_unit   <= TICKS_PER_UNIT_RST;
      ack_timeout      <= ACK_TIMEOUT_RST;
      phase            <= PH_IDLE;
      unit_counter     <= '0;
      delay_units_left <= '0;
      bit_index        <= '0;
      shift_reg        <= '0;
      rx_reg           <= '0;
      timeout_counter  <= '0;
      scl              <= 1'b1;
      sda              <= 1'b1;
      drv              <= 1'b1;
      ack_flag         <= 1'b0;
      m_tvalid         <= 1'b0;
    end else begin
      if (cfg_wr) begin
        if (paddr[2] == REG_ACK_TIMEOUT) begin
          ack_timeout <= pwdata[TOUT_W-1:0];
        end else begin
          ticks_per_unit <= pwdata[UNIT_W-1:0];
        end
      end
      if (accept) begin
        phase            <= phase_next;
        unit_counter     <= unit_counter_next;
        delay_units_left <= delay_units_left_next;
        bit_index        <= bit_index_next;
        shift_reg        <= shift_reg_next;
        rx_reg           <= rx_reg_next;
        timeout_counter  <= timeout_counter_next;
        scl              <= scl_next;
        sda              <= sda_next;
        drv              <= drv_next;
        ack_flag         <= ack_flag_next;
        m_tvalid         <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res <= res_next;
    end
  end

  // a finishing tick always reports idle
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(res.done_res && res.busy_res))
    else $error("done and busy reported together");

  // the poll phase never drives SDA
  a_poll_released: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_WACK_POLL) |-> !drv)
    else $error("SDA driven while polling for ack");

  a_delay_range: assert property (@(posedge clk) disable iff (rst)
    delay_units_left <= DLY_LONG)
    else $error("delay count out of range");

  a_bit_range: assert property (@(posedge clk) disable iff (rst)
    bit_index <= 4'(BYTE_BITS))
    else $error("bit index out of range");

  // a timeout raises the flag and launches a stop in the same step
  a_timeout_stop: assert property (@(posedge clk) disable iff (rst)
    $rose(ack_flag) |-> (phase == PH_STOP_A))
    else $error("ack_missing set without stop sequence");

endmodule

/* test/i2c_master_bit_engine_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_master_bit_engine_core_tb
// Self-checking bench for the I2C master bit engine. Tick words are queued
// together with the status word a local model of the sequencer expects for
// each one. A clocked driver and monitor move them with random gaps and
// stalls. Both registers are reprogrammed between phases, only once the
// sequencer has gone idle.
// ----------------------------------------------------------------------------
module i2c_master_bit_engine_core_tb;
  import i2cmbe_pkg::*;

  localparam logic [2:0] CMD_UNUSED = 3'd7;

  typedef enum logic [4:0] {
    ST_IDLE, ST_START_SETUP, ST_START_HOLD, ST_STOP_SETUP, ST_STOP_HOLD,
    ST_WACK_LOW, ST_WACK_HIGH, ST_WACK_POLL, ST_ABIT_LOW, ST_ABIT_HIGH,
    ST_TX_LOW, ST_TX_HIGH, ST_TX_GAP, ST_RX_LOW, ST_RX_HIGH
  } seq_t;

  typedef struct packed {
    in_user_t u;
    in_word_t w;
  } tick_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic [S_TUSER_W-1:0] s_tuser = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [PADDR_W-1:0]   paddr = '0;
  logic [PDATA_W-1:0]   pwdata = '0;
  logic [PDATA_W-1:0]   prdata;
  logic                 pready;

  i2c_master_bit_engine_core dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  tick_t     tick_q[$];
  out_word_t status_q[$];
  int        n_errors = 0;
  int        n_words = 0;
  int        n_items = 0;

  // sequencer model state
  seq_t        seq_st = ST_IDLE;
  int          unit_cnt = 0;
  logic [2:0]  units_left = '0;
  logic [3:0]  bit_cnt = '0;
  logic [7:0]  shreg = '0;
  logic [7:0]  rx_hold = '0;
  logic [7:0]  poll_cnt = '0;
  logic        scl_q = 1'b1;
  logic        sda_q = 1'b1;
  logic        drv_q = 1'b1;
  logic        ack_miss_q = 1'b0;
  logic        done_q = 1'b0;
  logic        rx_acks = 1'b0;
  logic [15:0] tpu_cfg = TICKS_PER_UNIT_RST;
  logic [7:0]  ack_to_cfg = ACK_TIMEOUT_RST;

  function automatic void seq_enter(seq_t s, logic [2:0] units);
    seq_st = s;
    units_left = units;
    unit_cnt = 0;
  endfunction

  function automatic void seq_finish();
    seq_st = ST_IDLE;
    units_left = '0;
    unit_cnt = 0;
    done_q = 1'b1;
  endfunction

  function automatic void seq_stop();
    drv_q = 1'b1;
    scl_q = 1'b0;
    sda_q = 1'b0;
    seq_enter(ST_STOP_SETUP, DLY_LONG);
  endfunction

  function automatic void seq_ackbit(logic lvl);
    scl_q = 1'b0;
    drv_q = 1'b1;
    sda_q = lvl;
    seq_enter(ST_ABIT_LOW, DLY_MID);
  endfunction

  function automatic void seq_accept(logic [2:0] op, logic [7:0] tx, logic ackr);
    case (op)
      CMD_START: begin
        drv_q = 1'b1; sda_q = 1'b1; scl_q = 1'b1;
        seq_enter(ST_START_SETUP, DLY_LONG);
      end
      CMD_STOP: seq_stop();
      CMD_SEND: begin
        drv_q = 1'b1; scl_q = 1'b0;
        shreg = tx;
        bit_cnt = '0;
        sda_q = shreg[7];
        seq_enter(ST_TX_LOW, DLY_MID);
      end
      CMD_WACK: begin
        ack_miss_q = 1'b0;
        drv_q = 1'b0; sda_q = 1'b1;
        seq_enter(ST_WACK_LOW, DLY_SHORT);
      end
      CMD_ACK:  seq_ackbit(1'b0);
      CMD_NACK: seq_ackbit(1'b1);
      CMD_READ: begin
        drv_q = 1'b0; scl_q = 1'b0;
        shreg = '0;
        bit_cnt = '0;
        rx_acks = ackr;
        seq_enter(ST_RX_LOW, DLY_MID);
      end
      default: ;
    endcase
  endfunction

  // what happens when the running delay has expired
  function automatic void seq_advance(logic sda_in);
    case (seq_st)
      ST_START_SETUP: begin sda_q = 1'b0; seq_enter(ST_START_HOLD, DLY_LONG); end
      ST_START_HOLD:  begin scl_q = 1'b0; seq_finish(); end
      ST_STOP_SETUP: begin
        scl_q = 1'b1; sda_q = 1'b1;
        seq_enter(ST_STOP_HOLD, DLY_LONG);
      end
      ST_STOP_HOLD:  seq_finish();
      ST_WACK_LOW:   begin scl_q = 1'b1; seq_enter(ST_WACK_HIGH, DLY_SHORT); end
      ST_WACK_HIGH:  begin poll_cnt = '0; seq_enter(ST_WACK_POLL, DLY_NONE); end
      ST_ABIT_LOW:   begin scl_q = 1'b1; seq_enter(ST_ABIT_HIGH, DLY_MID); end
      ST_ABIT_HIGH:  begin scl_q = 1'b0; seq_finish(); end
      ST_TX_LOW:     begin scl_q = 1'b1; seq_enter(ST_TX_HIGH, DLY_MID); end
      ST_TX_HIGH:    begin scl_q = 1'b0; seq_enter(ST_TX_GAP, DLY_MID); end
      ST_TX_GAP: begin
        bit_cnt = bit_cnt + 4'd1;
        if (bit_cnt >= BYTE_BITS) begin
          seq_finish();
        end else begin
          shreg = {shreg[6:0], 1'b0};
          sda_q = shreg[7];
          seq_enter(ST_TX_LOW, DLY_MID);
        end
      end
      ST_RX_LOW: begin
        scl_q = 1'b1;
        shreg = {shreg[6:0], sda_in};
        seq_enter(ST_RX_HIGH, DLY_SHORT);
      end
      ST_RX_HIGH: begin
        bit_cnt = bit_cnt + 4'd1;
        if (bit_cnt >= BYTE_BITS) begin
          rx_hold = shreg;
          seq_ackbit(!rx_acks);
        end else begin
          scl_q = 1'b0;
          seq_enter(ST_RX_LOW, DLY_MID);
        end
      end
      default: seq_st = ST_IDLE;
    endcase
  endfunction

  function automatic out_word_t bus_tick(in_user_t u, in_word_t w);
    out_word_t st;
    int        tpu_eff;
    tpu_eff = (tpu_cfg == 16'd0) ? 1 : int'(tpu_cfg);
    done_q = 1'b0;
    if (seq_st == ST_IDLE) begin
      if (u.cmd_valid) seq_accept(u.cmd, w.tx_byte, w.ack_after_read);
    end else if (seq_st == ST_WACK_POLL) begin
      if (!w.sda_in) begin
        scl_q = 1'b0;
        seq_finish();
      end else begin
        if (poll_cnt < 8'd255) poll_cnt = poll_cnt + 8'd1;
        if (poll_cnt > ack_to_cfg) begin
          ack_miss_q = 1'b1;
          seq_stop();
        end
      end
    end else begin
      unit_cnt++;
      if (unit_cnt >= tpu_eff) begin
        unit_cnt = 0;
        if (units_left > 3'd0) units_left = units_left - 3'd1;
      end
      if (units_left == 3'd0) seq_advance(w.sda_in);
    end
    st = '0;
    st.scl_level   = scl_q;
    st.sda_level   = sda_q;
    st.sda_driving = drv_q;
    st.busy_res    = (seq_st != ST_IDLE);
    st.done_res    = done_q;
    st.rx_byte     = rx_hold;
    st.ack_missing = ack_miss_q;
    return st;
  endfunction

  // ---- stimulus helpers ----

  task automatic push_tick(logic valid, logic [2:0] op, logic [7:0] tx, logic ackr,
                           logic sda);
    tick_t t;
    t.u.cmd_valid = valid;
    t.u.cmd = op;
    t.w = '0;
    t.w.tx_byte = tx;
    t.w.ack_after_read = ackr;
    t.w.sda_in = sda;
    n_items++;
    status_q.push_back(bus_tick(t.u, t.w));
    tick_q.push_back(t);
  endtask

  task automatic idle_ticks(int n);
    repeat (n) push_tick(1'b0, 3'($urandom_range(0, 7)), 8'($urandom),
                         1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endtask

  // issue one command at idle and tick until it completes; high_polls sets
  // how many wait-ack polls see SDA high before it is pulled low
  task automatic run_cmd(logic [2:0] op, logic [7:0] tx, logic ackr, int high_polls,
                         int noise_pct);
    int   polls;
    logic sda;
    polls = 0;
    push_tick(1'b1, op, tx, ackr, 1'($urandom_range(0, 1)));
    while (seq_st != ST_IDLE) begin
      if (seq_st == ST_WACK_POLL) begin
        sda = (polls < high_polls);
        polls++;
      end else begin
        sda = 1'($urandom_range(0, 1));
      end
      push_tick($urandom_range(0, 99) < noise_pct, 3'($urandom_range(0, 7)),
                8'($urandom), 1'($urandom_range(0, 1)), sda);
    end
  endtask

  function automatic int pick_polls();
    if ($urandom_range(0, 4) == 0 && ack_to_cfg != 8'd255) return int'(ack_to_cfg) + 1;
    return $urandom_range(0, 2);
  endfunction

  // a bus transfer: start, address, ack, up to two data bytes, stop
  task automatic run_transfer();
    int n_data;
    n_data = $urandom_range(0, 2);
    run_cmd(CMD_START, 8'($urandom), 1'b0, 0, 10);
    run_cmd(CMD_SEND, 8'($urandom), 1'b0, 0, 10);
    run_cmd(CMD_WACK, 8'($urandom), 1'b0, pick_polls(), 10);
    repeat (n_data) begin
      if ($urandom_range(0, 1)) begin
        run_cmd(CMD_SEND, 8'($urandom), 1'b0, 0, 10);
        run_cmd(CMD_WACK, 8'($urandom), 1'b0, pick_polls(), 10);
      end else begin
        run_cmd(CMD_READ, 8'($urandom), 1'($urandom_range(0, 1)), 0, 10);
      end
    end
    // now and then the stop is left out
    if ($urandom_range(0, 9) != 0) run_cmd(CMD_STOP, 8'($urandom), 1'b0, 0, 10);
  endtask

  task automatic drain();
    while (tick_q.size() != 0 || status_q.size() != 0) @(posedge clk);
  endtask

  task automatic set_reg(logic sel, logic [PDATA_W-1:0] value);
    drain();
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {sel, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (sel == REG_TICKS_PER_UNIT) tpu_cfg = value[UNIT_W-1:0];
    else ack_to_cfg = value[TOUT_W-1:0];
  endtask

  // ---- driver ----
  tick_t cur_tick;
  int    send_gap = 0;
  bit    send_steady = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (s_tvalid) begin
        if ($urandom_range(0, 19) == 0) send_steady = !send_steady;
        send_gap = send_steady ? 0 : $urandom_range(0, 14);
      end
      if (send_gap > 0) begin
        send_gap--;
        s_tvalid <= 1'b0;
      end else if (tick_q.size() > 0) begin
        cur_tick = tick_q.pop_front();
        s_tvalid <= 1'b1;
        s_tdata <= cur_tick.w;
        s_tuser <= cur_tick.u;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // ---- monitor ----
  out_word_t seen_word, want_word;
  int        recv_stall = 0;
  bit        recv_steady = 1'b0;

  task automatic flag_mismatch(string field, int got, int want);
    n_errors++;
    $display("mismatch at status word %0d, %s: got %0h, expected %0h",
             n_words, field, got, want);
  endtask

  task automatic compare_status(out_word_t got, out_word_t want);
    if (got.scl_level !== want.scl_level)
      flag_mismatch("scl_level", int'(got.scl_level), int'(want.scl_level));
    if (got.sda_level !== want.sda_level)
      flag_mismatch("sda_level", int'(got.sda_level), int'(want.sda_level));
    if (got.sda_driving !== want.sda_driving)
      flag_mismatch("sda_driving", int'(got.sda_driving), int'(want.sda_driving));
    if (got.busy_res !== want.busy_res)
      flag_mismatch("busy_res", int'(got.busy_res), int'(want.busy_res));
    if (got.done_res !== want.done_res)
      flag_mismatch("done_res", int'(got.done_res), int'(want.done_res));
    if (got.rx_byte !== want.rx_byte)
      flag_mismatch("rx_byte", int'(got.rx_byte), int'(want.rx_byte));
    if (got.ack_missing !== want.ack_missing)
      flag_mismatch("ack_missing", int'(got.ack_missing), int'(want.ack_missing));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        seen_word = m_tdata;
        if (status_q.size() == 0) begin
          flag_mismatch("unexpected word", int'(seen_word), 0);
        end else begin
          want_word = status_q.pop_front();
          compare_status(seen_word, want_word);
        end
        n_words++;
        if ($urandom_range(0, 19) == 0) recv_steady = !recv_steady;
        recv_stall = recv_steady ? 0 : $urandom_range(0, 14);
      end
      if (recv_stall > 0) begin
        recv_stall--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // ---- sequence ----
  int budget;

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // default register values: one wait-ack at 72 ticks per unit
    idle_ticks(2);
    run_cmd(CMD_WACK, 8'h00, 1'b0, 0, 30);

    // zero unit length counts as one; zero timeout trips on the first high poll
    set_reg(REG_TICKS_PER_UNIT, 32'd0);
    set_reg(REG_ACK_TIMEOUT, 32'd0);
    run_cmd(CMD_START, 8'h00, 1'b0, 0, 0);
    run_cmd(CMD_SEND, 8'hFF, 1'b0, 0, 0);
    run_cmd(CMD_SEND, 8'h00, 1'b1, 0, 50);
    run_cmd(CMD_WACK, 8'h00, 1'b0, 0, 0);
    run_cmd(CMD_WACK, 8'hFF, 1'b1, 5, 50);
    run_cmd(CMD_READ, 8'hA5, 1'b1, 0, 0);
    run_cmd(CMD_READ, 8'h5A, 1'b0, 0, 50);
    run_cmd(CMD_ACK, 8'hFF, 1'b1, 0, 0);
    run_cmd(CMD_NACK, 8'h00, 1'b0, 0, 0);
    run_cmd(CMD_UNUSED, 8'hFF, 1'b1, 0, 0);
    run_cmd(CMD_STOP, 8'h00, 1'b0, 0, 0);
    idle_ticks(3);

    // largest timeout: the poll count saturates and only a low SDA ends it
    set_reg(REG_TICKS_PER_UNIT, 32'd1);
    set_reg(REG_ACK_TIMEOUT, 32'd255);
    run_cmd(CMD_WACK, 8'h00, 1'b0, 300, 0);
    run_cmd(CMD_WACK, 8'h00, 1'b0, 2, 20);

    // longest unit: no command is started, the lines must just hold
    set_reg(REG_TICKS_PER_UNIT, 32'd65535);
    idle_ticks(4);
    run_cmd(CMD_UNUSED, 8'h3C, 1'b0, 0, 0);
    idle_ticks(4);

    for (int ph = 0; ph < 4; ph++) begin
      set_reg(REG_TICKS_PER_UNIT, $urandom_range(0, 1));
      set_reg(REG_ACK_TIMEOUT, (ph == 2) ? 255 : $urandom_range(0, 4));
      budget = n_items + 60;
      while (n_items < budget) begin
        if ($urandom_range(0, 7) == 0) drain();
        if ($urandom_range(0, 4) == 0)
          run_cmd(3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom_range(0, 1)),
                  pick_polls(), 20);
        else
          run_transfer();
        idle_ticks($urandom_range(0, 2));
      end
    end

    drain();
    repeat (4) @(posedge clk);
    if (n_errors == 0 && status_q.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end

endmodule
